// ===== rtl/core/anf_pkg.sv =====
// Shared types and constants of the advertising name filter.
package anf_pkg;

	localparam int MAX_DEVICES      = 64;
	localparam int MAX_REPORT_BYTES = 255;
	localparam int DEV_IDX_W        = $clog2(MAX_DEVICES);
	localparam int DEV_CNT_W        = $clog2(MAX_DEVICES + 1);

	localparam int BYTE_W     = 8;
	localparam int ADDR_W     = 48;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 3;
	localparam int SLOT_W     = 6;
	localparam int CAP_W      = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [BYTE_W-1:0] TYPE_NAME_SHORT    = 8'h08;
	localparam logic [BYTE_W-1:0] TYPE_NAME_COMPLETE = 8'h09;

	localparam logic [CFG_IDX_W-1:0] REG_LIST_CAPACITY   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_NAME_LENGTH = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_DATA   = 2'd0,
		OP_END    = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED     = 3'd0,
		ST_NONAME    = 3'd1,
		ST_MALFORMED = 3'd2,
		ST_TOOLONG   = 3'd3,
		ST_DUP       = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		PH_LENGTH = 4'b0001,
		PH_TYPE   = 4'b0010,
		PH_DATA   = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		OC_NONE = 3'b001,
		OC_NAME = 3'b010,
		OC_BAD  = 3'b100
	} outcome_t;

	typedef enum logic [1:0] {
		BK_IDLE   = 2'b01,
		BK_SEARCH = 2'b10
	} back_state_t;

	typedef struct packed {
		logic                clear;
		logic                lookup;
		status_t             status;
		logic [ADDR_W-1:0]   addr;
		logic [BYTE_W-1:0]   name_offset;
		logic [BYTE_W-1:0]   name_length;
	} item_t;

endpackage

// ===== rtl/core/anf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module anf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/anf_queue.sv =====
// Short queue of classified report and clear items between front and back.
module anf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  anf_pkg::item_t push_item,
	input  logic           pop,
	output logic           valid,
	output anf_pkg::item_t head,
	output logic           full
);
	import anf_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign valid = (cnt_q != '0);
	assign full  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
		end
	end

endmodule

// ===== rtl/core/anf_front.sv =====
// Front part: walks advertising structures and classifies each report at its end.
module anf_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  anf_pkg::op_t               op,
	input  logic [anf_pkg::BYTE_W-1:0] ad_byte,
	input  logic [anf_pkg::ADDR_W-1:0] device_address,
	input  logic [anf_pkg::BYTE_W-1:0] max_name_length,
	output logic                       push,
	output anf_pkg::item_t             item
);
	import anf_pkg::*;

	logic [BYTE_W-1:0] pos_q, pos_d;
	logic [BYTE_W-1:0] rem_q, rem_d;
	logic [BYTE_W-1:0] off_q, off_d;
	logic [BYTE_W-1:0] len_q, len_d;
	phase_t            phase_q, phase_d;
	outcome_t          outcome_q, outcome_d;

	logic [BYTE_W-1:0] rem_dec;
	logic              is_name;
	logic              named;
	logic [BYTE_W:0]   span;
	logic              overrun;

	assign rem_dec = rem_q - 1'b1;
	assign is_name = (ad_byte == TYPE_NAME_SHORT) || (ad_byte == TYPE_NAME_COMPLETE);
	assign named   = (outcome_q == OC_NAME);
	assign span    = {1'b0, off_q} + {1'b0, len_q};
	assign overrun = (span > {1'b0, pos_q});
	assign push    = accept && ((op == OP_END) || (op == OP_CLEAR));

	always_comb begin
		pos_d     = pos_q;
		rem_d     = rem_q;
		off_d     = off_q;
		len_d     = len_q;
		phase_d   = phase_q;
		outcome_d = outcome_q;
		if (accept) begin
			unique case (op)
				OP_DATA: begin
					if (pos_q >= BYTE_W'(MAX_REPORT_BYTES)) begin
						outcome_d = OC_BAD;
					end else begin
						pos_d = pos_q + 1'b1;
						if (outcome_q != OC_BAD) begin
							unique case (phase_q)
								PH_LENGTH: begin
									if (ad_byte == '0) begin
										outcome_d = OC_BAD;
									end else begin
										rem_d   = ad_byte;
										phase_d = PH_TYPE;
									end
								end
								PH_TYPE: begin
									rem_d = rem_dec;
									priority if (is_name) begin
										off_d     = pos_q + 1'b1;
										len_d     = rem_dec;
										outcome_d = OC_NAME;
										phase_d   = PH_DONE;
									end else if (rem_dec == '0) begin
										phase_d = PH_LENGTH;
									end else begin
										phase_d = PH_DATA;
									end
								end
								PH_DATA: begin
									rem_d = rem_dec;
									if (rem_dec == '0) begin
										phase_d = PH_LENGTH;
									end
								end
								PH_DONE: begin
								end
								default: begin
								end
							endcase
						end
					end
				end
				OP_END: begin
					pos_d     = '0;
					rem_d     = '0;
					off_d     = '0;
					len_d     = '0;
					phase_d   = PH_LENGTH;
					outcome_d = OC_NONE;
				end
				OP_CLEAR, OP_UNUSED: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		item.clear       = (op == OP_CLEAR);
		item.lookup      = 1'b0;
		item.status      = ST_NONAME;
		item.addr        = device_address;
		item.name_offset = named ? off_q : '0;
		item.name_length = named ? len_q : '0;
		priority if (outcome_q == OC_BAD) begin
			item.status = ST_MALFORMED;
		end else if (outcome_q == OC_NONE) begin
			item.status = (phase_q == PH_LENGTH) ? ST_NONAME : ST_MALFORMED;
		end else if (overrun) begin
			item.status = ST_MALFORMED;
		end else if (len_q > max_name_length) begin
			item.status = ST_TOOLONG;
		end else begin
			item.lookup = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			rem_q     <= '0;
			off_q     <= '0;
			len_q     <= '0;
			phase_q   <= PH_LENGTH;
			outcome_q <= OC_NONE;
		end else begin
			pos_q     <= pos_d;
			rem_q     <= rem_d;
			off_q     <= off_d;
			len_q     <= len_d;
			phase_q   <= phase_d;
			outcome_q <= outcome_d;
		end
	end

endmodule

// ===== rtl/core/anf_back.sv =====
// Back part: searches the address table, appends new devices and issues verdicts.
module anf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid,
	input  anf_pkg::item_t               item,
	output logic                         pop,
	input  logic [anf_pkg::CAP_W-1:0]    list_capacity,
	output logic                         done,
	output logic [anf_pkg::STATUS_W-1:0] status,
	output logic [anf_pkg::SLOT_W-1:0]   slot,
	output logic [anf_pkg::BYTE_W-1:0]   name_offset,
	output logic [anf_pkg::BYTE_W-1:0]   name_length
);
	import anf_pkg::*;

	back_state_t          state_q;
	item_t                cur_q;
	logic [DEV_CNT_W-1:0] count_q;
	logic [DEV_CNT_W-1:0] idx_q;
	logic                 pend_s1;
	logic                 done_q;
	status_t              status_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [BYTE_W-1:0]    off_q;
	logic [BYTE_W-1:0]    len_q;

	logic [ADDR_W-1:0]    rdata;
	logic                 issue;
	logic                 hit;
	logic                 finish;
	logic                 full;
	logic                 wr_en;

	assign pop    = (state_q == BK_IDLE) && valid;
	assign issue  = (state_q == BK_SEARCH) && (idx_q < count_q);
	assign hit    = (state_q == BK_SEARCH) && pend_s1 && (rdata == cur_q.addr);
	assign finish = (state_q == BK_SEARCH) && !hit && !issue && !pend_s1;
	assign full   = (32'(count_q) >= MAX_DEVICES) || (32'(count_q) >= 32'(list_capacity));
	assign wr_en  = finish && !full;

	assign done        = done_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign name_offset = off_q;
	assign name_length = len_q;

	anf_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(MAX_DEVICES)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[DEV_IDX_W-1:0]),
		.wdata(cur_q.addr),
		.re   (issue),
		.raddr(idx_q[DEV_IDX_W-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= (pop && !item.clear && !item.lookup) || hit || finish;
			pend_s1 <= issue && !hit;
			unique case (state_q)
				BK_IDLE: begin
					if (valid) begin
						if (item.clear) begin
							count_q <= '0;
						end else if (item.lookup) begin
							state_q <= BK_SEARCH;
						end
					end
				end
				BK_SEARCH: begin
					if (hit) begin
						state_q <= BK_IDLE;
					end else if (finish) begin
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (valid) begin
					cur_q    <= item;
					idx_q    <= '0;
					status_q <= item.status;
					slot_q   <= '0;
					off_q    <= item.name_offset;
					len_q    <= item.name_length;
				end
			end
			BK_SEARCH: begin
				if (hit) begin
					status_q <= ST_DUP;
					slot_q   <= '0;
					off_q    <= cur_q.name_offset;
					len_q    <= cur_q.name_length;
				end else if (finish) begin
					status_q <= full ? ST_FULL : ST_ADDED;
					slot_q   <= full ? '0 : SLOT_W'(count_q);
					off_q    <= cur_q.name_offset;
					len_q    <= cur_q.name_length;
				end else begin
					idx_q <= idx_q + DEV_CNT_W'(issue);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/advertising_name_filter.sv =====
// Advertising name filter: parses report data and keeps a table of named devices.
// Data bytes and other beats are taken whenever start is high and busy is low.
// An end-of-report verdict is queued as an item and given on the registered done output;
// a lookup item first searches the table, one entry per cycle, before its verdict.
// Busy rises only while the four-deep item queue is full. The receiver cannot stall.
// Reset clears parse state and device count; capacity returns to 64, name limit to 30.
module advertising_name_filter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [anf_pkg::OP_W-1:0]       op,
	input  logic [anf_pkg::BYTE_W-1:0]     ad_byte,
	input  logic [anf_pkg::ADDR_W-1:0]     device_address,
	output logic                           done,
	output logic [anf_pkg::STATUS_W-1:0]   status,
	output logic [anf_pkg::SLOT_W-1:0]     slot,
	output logic [anf_pkg::BYTE_W-1:0]     name_offset,
	output logic [anf_pkg::BYTE_W-1:0]     name_length,
	input  logic                           wr_en,
	input  logic [anf_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [anf_pkg::CFG_DATA_W-1:0] wr_data
);
	import anf_pkg::*;

	logic [CAP_W-1:0]  list_capacity_q;
	logic [BYTE_W-1:0] max_name_length_q;

	logic  accept;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  q_valid;
	item_t q_head;
	logic  q_full;

	assign busy   = q_full;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_capacity_q   <= CAP_W'(MAX_DEVICES);
			max_name_length_q <= BYTE_W'(30);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LIST_CAPACITY:   list_capacity_q   <= wr_data[CAP_W-1:0];
				REG_MAX_NAME_LENGTH: max_name_length_q <= wr_data[BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	anf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.op             (op_t'(op)),
		.ad_byte        (ad_byte),
		.device_address (device_address),
		.max_name_length(max_name_length_q),
		.push           (push),
		.item           (push_item)
	);

	anf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.valid    (q_valid),
		.head     (q_head),
		.full     (q_full)
	);

	anf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (q_valid),
		.item         (q_head),
		.pop          (pop),
		.list_capacity(list_capacity_q),
		.done         (done),
		.status       (status),
		.slot         (slot),
		.name_offset  (name_offset),
		.name_length  (name_length)
	);

endmodule

// ===== sim/advertising_name_filter_tb.sv =====
// Testbench for advertising_name_filter: drives reports with random pacing and checks each verdict.
`timescale 1ns / 100ps

module advertising_name_filter_tb;
	import anf_pkg::*;

	localparam int SETTLE_CYCLES = QUEUE_DEPTH * (MAX_DEVICES + 4);
	localparam int STALL_LIMIT   = 4000;

	typedef struct {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [BYTE_W-1:0] name_offset;
		logic [BYTE_W-1:0] name_length;
	} verdict_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [OP_W-1:0]       op = OP_DATA;
	logic [BYTE_W-1:0]     ad_byte = '0;
	logic [ADDR_W-1:0]     device_address = '0;
	logic                  done;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_W-1:0]     slot;
	logic [BYTE_W-1:0]     name_offset;
	logic [BYTE_W-1:0]     name_length;
	logic                  wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	// predicted parser and table state
	logic [BYTE_W-1:0] rpt_pos;
	logic [BYTE_W-1:0] field_left;
	logic [BYTE_W-1:0] name_off;
	logic [BYTE_W-1:0] name_size;
	phase_t            rpt_phase;
	outcome_t          rpt_outcome;
	logic [ADDR_W-1:0] table_addr [MAX_DEVICES];
	int                table_count = 0;
	logic [CAP_W-1:0]  cap_setting = 7'd64;
	logic [BYTE_W-1:0] name_limit = 8'd30;

	verdict_t          verdicts_due [$];
	verdict_t          oldest;
	logic [BYTE_W-1:0] report_bytes [$];
	logic [ADDR_W-1:0] recent_addrs [$];
	int                mismatches = 0;
	int                beats_sent = 0;
	int                burst_left = 0;
	int                stall_cycles = 0;
	bit                noise_on = 1'b0;

	advertising_name_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.ad_byte(ad_byte),
		.device_address(device_address),
		.done(done),
		.status(status),
		.slot(slot),
		.name_offset(name_offset),
		.name_length(name_length),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void restart_report();
		rpt_pos     = '0;
		field_left  = '0;
		name_off    = '0;
		name_size   = '0;
		rpt_phase   = PH_LENGTH;
		rpt_outcome = OC_NONE;
	endfunction

	function automatic void parse_ad_byte(input logic [BYTE_W-1:0] b);
		if (rpt_pos >= MAX_REPORT_BYTES) begin
			rpt_outcome = OC_BAD;
			return;
		end
		rpt_pos = rpt_pos + 1'b1;
		if (rpt_outcome == OC_BAD)
			return;
		case (rpt_phase)
			PH_LENGTH: begin
				if (b == '0) begin
					rpt_outcome = OC_BAD;
				end else begin
					field_left = b;
					rpt_phase  = PH_TYPE;
				end
			end
			PH_TYPE: begin
				field_left = field_left - 1'b1;
				if (b == TYPE_NAME_SHORT || b == TYPE_NAME_COMPLETE) begin
					name_off    = rpt_pos;
					name_size   = field_left;
					rpt_outcome = OC_NAME;
					rpt_phase   = PH_DONE;
				end else if (field_left == '0) begin
					rpt_phase = PH_LENGTH;
				end else begin
					rpt_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				field_left = field_left - 1'b1;
				if (field_left == '0)
					rpt_phase = PH_LENGTH;
			end
			default: ;
		endcase
	endfunction

	function automatic verdict_t judge_report(input logic [ADDR_W-1:0] a);
		verdict_t v;
		int       cap;
		v.slot        = '0;
		v.name_offset = (rpt_outcome == OC_NAME) ? name_off : '0;
		v.name_length = (rpt_outcome == OC_NAME) ? name_size : '0;
		cap = (cap_setting > MAX_DEVICES) ? MAX_DEVICES : int'(cap_setting);
		if (rpt_outcome == OC_BAD) begin
			v.status = ST_MALFORMED;
		end else if (rpt_outcome == OC_NONE) begin
			v.status = (rpt_phase == PH_LENGTH) ? ST_NONAME : ST_MALFORMED;
		end else if (int'(name_off) + int'(name_size) > int'(rpt_pos)) begin
			v.status = ST_MALFORMED;
		end else if (name_size > name_limit) begin
			v.status = ST_TOOLONG;
		end else begin
			v.status = ST_ADDED;
			for (int i = 0; i < table_count; i++)
				if (table_addr[i] == a)
					v.status = ST_DUP;
			if (v.status == ST_ADDED) begin
				if (table_count >= cap) begin
					v.status = ST_FULL;
				end else begin
					table_addr[table_count] = a;
					v.slot = SLOT_W'(table_count);
					table_count++;
				end
			end
		end
		restart_report();
		return v;
	endfunction

	task automatic check_field(input string what, input logic [7:0] got, input logic [7:0] want);
		if (got !== want) begin
			mismatches++;
			$display("%0t %s expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (verdicts_due.size() == 0) begin
				mismatches++;
				$display("%0t verdict expected none actual status %0d", $time, status);
			end else begin
				oldest = verdicts_due.pop_front();
				check_field("status", 8'(status), 8'(oldest.status));
				check_field("slot", 8'(slot), 8'(oldest.slot));
				check_field("name_offset", name_offset, oldest.name_offset);
				check_field("name_length", name_length, oldest.name_length);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || wr_en)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("advertising_name_filter: mismatch");
			$finish;
		end
	end

	task automatic send_item(input op_t o, input logic [BYTE_W-1:0] b, input logic [ADDR_W-1:0] a);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start          <= 1'b1;
		op             <= o;
		ad_byte        <= b;
		device_address <= a;
		do @(posedge clk); while (busy);
		case (o)
			OP_DATA: parse_ad_byte(b);
			OP_END: verdicts_due.push_back(judge_report(a));
			OP_CLEAR: table_count = 0;
			default: ;
		endcase
		if (o != OP_UNUSED)
			beats_sent++;
	endtask

	task automatic send_report(input logic [ADDR_W-1:0] a);
		foreach (report_bytes[i]) begin
			if (noise_on && $urandom_range(0, 49) == 0)
				send_item(OP_UNUSED, BYTE_W'($urandom_range(0, 255)),
					ADDR_W'({$urandom, $urandom}));
			if (noise_on && $urandom_range(0, 299) == 0)
				send_item(OP_CLEAR, BYTE_W'($urandom_range(0, 255)),
					ADDR_W'({$urandom, $urandom}));
			send_item(OP_DATA, report_bytes[i], ADDR_W'({$urandom, $urandom}));
		end
		send_item(OP_END, BYTE_W'($urandom_range(0, 255)), a);
		report_bytes.delete();
	endtask

	task automatic push_struct(input logic [BYTE_W-1:0] typ, input int len);
		report_bytes.push_back(BYTE_W'(len));
		report_bytes.push_back(typ);
		repeat (len - 1) report_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		if (idx == REG_LIST_CAPACITY)
			cap_setting = val[CAP_W-1:0];
		else
			name_limit = val;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic quiesce();
		start <= 1'b0;
		burst_left = 0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_parse_cases();
		send_report(48'h0000_0000_0000);
		report_bytes = '{8'h00};
		send_report(48'hFFFF_FFFF_FFFF);
		report_bytes = '{8'h02, TYPE_NAME_SHORT, 8'h41};
		send_report(48'h0000_0000_00A1);
		report_bytes = '{8'h02, 8'h01, 8'h02, TYPE_NAME_COMPLETE, 8'h5A};
		send_report(48'h0000_0000_00B2);
		report_bytes = '{8'hFF, TYPE_NAME_COMPLETE, 8'h41};
		send_report(48'h8000_0000_0003);
		report_bytes = '{8'h02, 8'h01};
		send_report(48'h0000_0000_0004);
		// unused op and clear land inside a report that must carry on
		send_item(OP_DATA, 8'h02, '0);
		send_item(OP_DATA, TYPE_NAME_SHORT, '0);
		send_item(OP_UNUSED, 8'hFF, 48'hFFFF_FFFF_FFFF);
		send_item(OP_CLEAR, 8'h00, '0);
		send_item(OP_DATA, 8'h41, '0);
		send_item(OP_END, 8'h00, 48'h0000_0000_00A1);
	endtask

	task automatic test_name_limit();
		quiesce();
		write_reg(REG_MAX_NAME_LENGTH, 8'd0);
		report_bytes = '{8'h01, TYPE_NAME_SHORT};
		send_report(48'h1111_0000_0001);
		report_bytes = '{8'h02, TYPE_NAME_COMPLETE, 8'h41};
		send_report(48'h1111_0000_0002);
		quiesce();
		write_reg(REG_MAX_NAME_LENGTH, 8'd255);
		report_bytes = '{8'h03, TYPE_NAME_COMPLETE, 8'h41, 8'h42};
		send_report(48'h1111_0000_0003);
	endtask

	task automatic test_table_capacity();
		quiesce();
		write_reg(REG_LIST_CAPACITY, 8'd64);
		send_item(OP_CLEAR, 8'h00, '0);
		for (int i = 0; i < MAX_DEVICES; i++) begin
			push_struct(TYPE_NAME_COMPLETE, 2);
			send_report(48'h2222_0000_0000 + ADDR_W'(i));
		end
		push_struct(TYPE_NAME_SHORT, 2);
		send_report(48'h2222_0000_000A);
		push_struct(TYPE_NAME_SHORT, 2);
		send_report(48'h2222_0001_0000);
		quiesce();
		write_reg(REG_LIST_CAPACITY, 8'd0);
		send_item(OP_CLEAR, 8'h00, '0);
		push_struct(TYPE_NAME_COMPLETE, 3);
		send_report(48'h3333_0000_0001);
		quiesce();
		write_reg(REG_LIST_CAPACITY, 8'd1);
		push_struct(TYPE_NAME_COMPLETE, 3);
		send_report(48'h3333_0000_0001);
		push_struct(TYPE_NAME_COMPLETE, 3);
		send_report(48'h3333_0000_0002);
		quiesce();
		write_reg(REG_LIST_CAPACITY, 8'd200);
	endtask

	task automatic test_long_reports();
		quiesce();
		write_reg(REG_MAX_NAME_LENGTH, 8'd254);
		send_item(OP_CLEAR, 8'h00, '0);
		// exactly the longest report, its name reaching the last byte
		push_struct(TYPE_NAME_COMPLETE, 254);
		send_report(48'h4444_0000_0001);
		// one byte over: the position saturates
		push_struct(TYPE_NAME_COMPLETE, 254);
		report_bytes.push_back(8'h7F);
		send_report(48'h4444_0000_0002);
	endtask

	task automatic test_random_reports();
		int                target;
		int                n;
		logic [BYTE_W-1:0] typ;
		logic [ADDR_W-1:0] a;
		noise_on = 1'b1;
		for (int phase_no = 0; phase_no < 4; phase_no++) begin
			quiesce();
			case ($urandom_range(0, 3))
				0: write_reg(REG_LIST_CAPACITY, CFG_DATA_W'($urandom_range(0, 6)));
				1: write_reg(REG_LIST_CAPACITY, 8'd64);
				default: write_reg(REG_LIST_CAPACITY, CFG_DATA_W'($urandom_range(0, 255)));
			endcase
			if ($urandom_range(0, 1) == 0)
				write_reg(REG_MAX_NAME_LENGTH, CFG_DATA_W'($urandom_range(0, 24)));
			else
				write_reg(REG_MAX_NAME_LENGTH, CFG_DATA_W'($urandom_range(0, 255)));
			target = beats_sent + 60;
			while (beats_sent < target) begin
				n = $urandom_range(0, 4);
				repeat (n) begin
					if ($urandom_range(0, 9) < 3)
						typ = $urandom_range(0, 1) ? TYPE_NAME_COMPLETE : TYPE_NAME_SHORT;
					else
						typ = BYTE_W'($urandom_range(0, 255));
					push_struct(typ, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60)
						: $urandom_range(1, 12));
				end
				// now and then add five long structures that can run past the longest report
				if ($urandom_range(0, 39) == 0)
					repeat (5) push_struct(BYTE_W'($urandom_range(0, 255)),
						$urandom_range(40, 60));
				case ($urandom_range(0, 11))
					0: repeat ($urandom_range(1, 3))
						if (report_bytes.size() > 0)
							report_bytes.delete(report_bytes.size() - 1);
					1: report_bytes.insert($urandom_range(0, report_bytes.size()), 8'h00);
					2: repeat ($urandom_range(1, 6))
						report_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
					default: ;
				endcase
				if (recent_addrs.size() > 0 && $urandom_range(0, 2) == 0) begin
					a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
				end else begin
					a = ADDR_W'({$urandom, $urandom});
					recent_addrs.push_back(a);
					if (recent_addrs.size() > 24)
						recent_addrs.delete(0);
				end
				send_report(a);
			end
		end
		noise_on = 1'b0;
	endtask

	initial begin
		restart_report();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_parse_cases();
		test_name_limit();
		test_table_capacity();
		test_long_reports();
		test_random_reports();
		quiesce();
		if (mismatches == 0)
			$display("advertising_name_filter: match");
		else
			$display("advertising_name_filter: mismatch");
		$finish;
	end

endmodule
